// ===== rtl/pointer_command_smoother_top_macros.svh =====
// Assertion macros used by the RTL top file of the pointer command smoother.
`ifndef POINTER_COMMAND_SMOOTHER_TOP_MACROS_SVH
`define POINTER_COMMAND_SMOOTHER_TOP_MACROS_SVH

// Check a property on every rising edge, skipped while reset is asserted.
`define PCS_ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Check a property on every rising edge, reset included.
`define PCS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/pcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pcs_pkg;

    localparam logic [2:0] CMD_MOVE  = 3'd2;
    localparam logic [2:0] CMD_LEFT  = 3'd3;
    localparam logic [2:0] CMD_RIGHT = 3'd4;
    localparam logic [2:0] CMD_WHEEL = 3'd5;

    localparam logic [1:0] ACT_DOWN = 2'd0;
    localparam logic [1:0] ACT_UP   = 2'd1;
    localparam logic [1:0] ACT_MOVE = 2'd2;

    localparam logic signed [7:0] WHEEL_STEP_UP   = 8'sd80;
    localparam logic signed [7:0] WHEEL_STEP_DOWN = -8'sd80;
    localparam logic signed [7:0] WHEEL_NONE      = 8'sd0;

    typedef enum logic [2:0] {
        KIND_MOVE  = 3'd0,
        KIND_LDOWN = 3'd1,
        KIND_LUP   = 3'd2,
        KIND_RDOWN = 3'd3,
        KIND_RUP   = 3'd4,
        KIND_WHEEL = 3'd5
    } kind_t;

    typedef struct packed {
        logic             has_result;
        logic             is_move;
        kind_t            kind;
        logic signed [7:0] wheel;
    } evt_t;

endpackage

`default_nettype wire

// ===== rtl/pointer_command_smoother_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pointer command smoother. Input transfers carry command and action in s_tuser and the
// two signed coordinates in s_tdata; each result transfer carries the event kind in m_tuser
// and the smoothed motion and wheel step in m_tdata. One transfer is accepted every clock
// cycle when the result side keeps up; a result passes from the input register into the
// result register before it is offered on m_tvalid, and waits in the input register while
// the result side stalls. The rate is set by the combinational path from the input
// register through the five-sample sums and the reciprocal multiply that divides by
// five. Commands that produce no event still pass through the input register and keep
// their wheel state updates in order.

`include "pointer_command_smoother_top_macros.svh"

module pointer_command_smoother_top #(
    parameter int COORD_BITS = 16
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // coord_x, coord_y, zero pad
    input  wire  [((2*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // command, action
    input  wire  [4:0]                       s_tuser,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // move_dx, move_dy, wheel_amount, zero pad
    output logic [((2*COORD_BITS+15)/8)*8-1:0] m_tdata,
    // event_kind
    output logic [2:0]                       m_tuser
);

    localparam int M_DATA_W = ((2*COORD_BITS+15)/8)*8;

    logic                         in_valid_reg, in_valid_next;
    logic [2:0]                   cmd_reg, cmd_next;
    logic [1:0]                   act_reg, act_next;
    logic signed [COORD_BITS-1:0] x_reg, x_next;
    logic signed [COORD_BITS-1:0] y_reg, y_next;

    logic                         m_valid_reg, m_valid_next;
    pcs_pkg::kind_t               kind_reg, kind_next;
    logic signed [COORD_BITS-1:0] dx_reg, dx_next;
    logic signed [COORD_BITS-1:0] dy_reg, dy_next;
    logic signed [7:0]            wheel_reg, wheel_next;

    logic                         out_free;
    logic                         step;
    logic                         in_take;
    logic                         move_step;
    logic signed [COORD_BITS-1:0] avg_x;
    logic signed [COORD_BITS-1:0] avg_y;
    pcs_pkg::evt_t                evt;

    assign out_free  = !m_valid_reg || m_tready;
    assign step      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign in_take   = s_tvalid && s_tready;
    assign move_step = step && evt.is_move;

    pcs_axis_avg #(
        .COORD_BITS(COORD_BITS)
    ) u_avg_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (move_step),
        .sample   (x_reg),
        .avg      (avg_x)
    );

    pcs_axis_avg #(
        .COORD_BITS(COORD_BITS)
    ) u_avg_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (move_step),
        .sample   (y_reg),
        .avg      (avg_y)
    );

    pcs_event_gen #(
        .COORD_BITS(COORD_BITS)
    ) u_event (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (step),
        .command  (cmd_reg),
        .action   (act_reg),
        .coord_y  (y_reg),
        .evt      (evt)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        cmd_next      = cmd_reg;
        act_next      = act_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
            cmd_next      = s_tuser[2:0];
            act_next      = s_tuser[4:3];
            x_next        = s_tdata[COORD_BITS-1:0];
            y_next        = s_tdata[2*COORD_BITS-1:COORD_BITS];
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        kind_next    = kind_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        wheel_next   = wheel_reg;
        if (step) begin
            m_valid_next = evt.has_result;
            if (evt.has_result) begin
                kind_next  = evt.kind;
                dx_next    = evt.is_move ? avg_x : '0;
                dy_next    = evt.is_move ? avg_y : '0;
                wheel_next = evt.wheel;
            end
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        act_reg   <= act_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        kind_reg  <= kind_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        wheel_reg <= wheel_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = M_DATA_W'({wheel_reg, dy_reg, dx_reg});

    `PCS_ASSERT_ALWAYS(a_reset_clears, aclk,
        !aresetn |=> !in_valid_reg && !m_valid_reg,
        "stage valid bits not cleared by reset")
    `PCS_ASSERT_RST(a_hold_pending, aclk, aresetn,
        in_valid_reg && !out_free |=> in_valid_reg && $stable(cmd_reg) && $stable(y_reg),
        "pending command lost while result side stalled")
    `PCS_ASSERT_RST(a_motion_only_on_move, aclk, aresetn,
        m_valid_reg && kind_reg != pcs_pkg::KIND_MOVE |-> dx_reg == '0 && dy_reg == '0,
        "nonzero motion on a non-move event")
    `PCS_ASSERT_RST(a_wheel_only_on_wheel, aclk, aresetn,
        m_valid_reg |-> (kind_reg == pcs_pkg::KIND_WHEEL) == (wheel_reg != '0),
        "wheel step does not match event kind")

endmodule

`default_nettype wire

// ===== rtl/pcs_axis_avg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcs_axis_avg #(
    parameter int COORD_BITS = 16
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          shift_en,
    input  wire  signed [COORD_BITS-1:0] sample,
    output logic signed [COORD_BITS-1:0] avg
);

    localparam int SUM_W   = COORD_BITS + 3;
    localparam int MAG_W   = COORD_BITS + 2;
    localparam int SHIFT   = MAG_W + 3;
    localparam int RECIP_W = MAG_W + 1;
    localparam int PROD_W  = MAG_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DIV5_RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'd4) / 64'd5);

    logic signed [COORD_BITS-1:0] hist_reg  [4];
    logic signed [COORD_BITS-1:0] hist_next [4];

    logic signed [SUM_W-1:0]      sum;
    logic                         all_nonzero;
    logic                         sum_neg;
    logic [MAG_W-1:0]             mag;
    logic [PROD_W-1:0]            prod;
    logic [COORD_BITS-1:0]        quot;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            hist_next[i] = hist_reg[i+1];
        end
        hist_next[3] = sample;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                hist_reg[i] <= '0;
            end
        end else if (shift_en) begin
            for (int i = 0; i < 4; i++) begin
                hist_reg[i] <= hist_next[i];
            end
        end
    end

    always_comb begin
        sum = {{3{sample[COORD_BITS-1]}}, sample};
        all_nonzero = (sample != '0);
        for (int i = 0; i < 4; i++) begin
            sum = sum + {{3{hist_reg[i][COORD_BITS-1]}}, hist_reg[i]};
            if (hist_reg[i] == '0) begin
                all_nonzero = 1'b0;
            end
        end
    end

    // Truncate toward zero: divide the magnitude, then restore the sign.
    assign sum_neg = sum[SUM_W-1];
    assign mag     = sum_neg ? MAG_W'(-sum) : MAG_W'(sum);
    assign prod    = PROD_W'(mag) * PROD_W'(DIV5_RECIP);
    assign quot    = prod[SHIFT +: COORD_BITS];

    always_comb begin
        if (!all_nonzero) begin
            avg = '0;
        end else if (sum_neg) begin
            avg = -$signed(quot);
        end else begin
            avg = $signed(quot);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pcs_event_gen.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcs_event_gen #(
    parameter int COORD_BITS = 16
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         step_en,
    input  wire  [2:0]                  command,
    input  wire  [1:0]                  action,
    input  wire signed [COORD_BITS-1:0] coord_y,
    output pcs_pkg::evt_t               evt
);

    logic signed [COORD_BITS-1:0] wheel_y_reg;
    logic signed [COORD_BITS-1:0] wheel_y_next;
    logic                         wheel_latch;

    always_comb begin
        evt.has_result = 1'b0;
        evt.is_move    = 1'b0;
        evt.kind       = pcs_pkg::KIND_MOVE;
        evt.wheel      = pcs_pkg::WHEEL_NONE;
        wheel_latch    = 1'b0;
        unique case (command)
            pcs_pkg::CMD_MOVE: begin
                evt.has_result = 1'b1;
                evt.is_move    = 1'b1;
            end
            pcs_pkg::CMD_LEFT, pcs_pkg::CMD_RIGHT: begin
                if (action == pcs_pkg::ACT_DOWN) begin
                    evt.has_result = 1'b1;
                    evt.kind = (command == pcs_pkg::CMD_LEFT) ?
                               pcs_pkg::KIND_LDOWN : pcs_pkg::KIND_RDOWN;
                end else if (action == pcs_pkg::ACT_UP) begin
                    evt.has_result = 1'b1;
                    evt.kind = (command == pcs_pkg::CMD_LEFT) ?
                               pcs_pkg::KIND_LUP : pcs_pkg::KIND_RUP;
                end
            end
            pcs_pkg::CMD_WHEEL: begin
                if (action == pcs_pkg::ACT_DOWN) begin
                    wheel_latch = 1'b1;
                end else if (action == pcs_pkg::ACT_MOVE) begin
                    wheel_latch = 1'b1;
                    evt.kind    = pcs_pkg::KIND_WHEEL;
                    if (coord_y > wheel_y_reg) begin
                        evt.has_result = 1'b1;
                        evt.wheel      = pcs_pkg::WHEEL_STEP_DOWN;
                    end else if (coord_y < wheel_y_reg) begin
                        evt.has_result = 1'b1;
                        evt.wheel      = pcs_pkg::WHEEL_STEP_UP;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign wheel_y_next = (step_en && wheel_latch) ? coord_y : wheel_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wheel_y_reg <= '0;
        end else begin
            wheel_y_reg <= wheel_y_next;
        end
    end

endmodule

`default_nettype wire
